/* hw/rtl/dfr_pkg.sv */
`default_nettype none

package dfr_pkg;

  // Fixed field widths and bit positions
  localparam int unsigned WordW    = 64;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned BitsW    = 11;
  localparam int unsigned CntW     = 31;
  localparam int unsigned CntLsb   = 6;
  localparam int unsigned FinalBit = 63;

  // Stream position of the next word
  typedef enum logic [2:0] {
    PhHdr1 = 3'b001,
    PhHdr2 = 3'b010,
    PhData = 3'b100
  } phase_e;

  // Per-cell control, shared by every cell of a chain
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/dfr_cell.sv */
`default_nettype none

module dfr_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  dfr_pkg::cell_ctl_t     ctl_i,
  input  wire  [dfr_pkg::WordW-1:0]    load_i,
  input  wire  [dfr_pkg::WordW-1:0]    shift_i,
  output logic [dfr_pkg::WordW-1:0]    q_o,
  output logic [dfr_pkg::WordW-1:0]    nxt_o
);

  logic [dfr_pkg::WordW-1:0] word_q;
  logic [dfr_pkg::WordW-1:0] word_d;

  // Load wins over shift; otherwise hold
  always_comb begin
    if (ctl_i.load) begin
      word_d = load_i;
    end else if (ctl_i.shift) begin
      word_d = shift_i;
    end else begin
      word_d = word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign q_o   = word_q;
  assign nxt_o = word_d;

endmodule

`default_nettype wire

/* hw/rtl/hash_input_segment_deframer.sv */
// Channel   Dir  Handshake                     Payload
// din       in   din_valid_i / din_ready_o     din_word_i
// dout      out  dout_valid_o / dout_ready_i   block_word_o, word_index_o, block_bits_o,
//                                              message_end_o, block_done_o
//
// One input word per cycle unless stalled; a block's last word is taken like any other.
// A second cell row sends a block as WORDS_PER_BLOCK transfers, one per ready cycle.
// Input stalls only when a word would complete a block while the output row is still
// draining, so blocks shorter than WORDS_PER_BLOCK words limit throughput.
// Reset clears all cells and counters; no clearing pass is needed.
`default_nettype none

module hash_input_segment_deframer #(
  parameter int unsigned WORDS_PER_BLOCK = 17,
  parameter int unsigned BLOCK_BITS      = 1088
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          din_valid_i,
  output logic                         din_ready_o,
  input  wire  [dfr_pkg::WordW-1:0]    din_word_i,
  output logic                         dout_valid_o,
  input  wire                          dout_ready_i,
  output logic [dfr_pkg::WordW-1:0]    block_word_o,
  output logic [dfr_pkg::IdxW-1:0]     word_index_o,
  output logic [dfr_pkg::BitsW-1:0]    block_bits_o,
  output logic                         message_end_o,
  output logic                         block_done_o
);

  localparam int unsigned Wpb   = WORDS_PER_BLOCK;
  localparam int unsigned SlotW = $clog2(Wpb + 1);

  localparam logic [dfr_pkg::IdxW-1:0] LastIdx   = dfr_pkg::IdxW'(Wpb - 1);
  localparam logic [SlotW-1:0]         SlotFull  = SlotW'(Wpb);
  localparam logic [dfr_pkg::CntW-1:0] BlockBits = dfr_pkg::CntW'(BLOCK_BITS);

  dfr_pkg::phase_e             phase_q, phase_d;
  logic                        final_q, final_d;
  logic [dfr_pkg::CntW-1:0]    words_q, words_d;
  logic [dfr_pkg::CntW-1:0]    bits_q, bits_d;
  logic [SlotW-1:0]            slot_q, slot_d;

  logic                        busy_q, busy_d;
  logic [dfr_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [dfr_pkg::BitsW-1:0]   nbits_q, nbits_d;
  logic                        end_q, end_d;

  logic                        emit;
  logic                        data_step;
  logic                        in_fire;
  logic                        out_fire;
  logic                        out_last;
  logic                        out_free;

  dfr_pkg::cell_ctl_t          in_ctl;
  dfr_pkg::cell_ctl_t          out_ctl;

  logic [dfr_pkg::WordW-1:0]   store_q   [Wpb];
  logic [dfr_pkg::WordW-1:0]   store_nxt [Wpb];
  logic [dfr_pkg::WordW-1:0]   out_q     [Wpb];
  logic [dfr_pkg::WordW-1:0]   out_nxt   [Wpb];

  // Decode the incoming word against the current phase
  always_comb begin
    logic [dfr_pkg::CntW-1:0] words_v;
    logic [dfr_pkg::CntW-1:0] bits_v;
    logic                     final_v;
    phase_d   = phase_q;
    slot_d    = slot_q;
    words_v   = words_q;
    bits_v    = bits_q;
    final_v   = final_q;
    emit      = 1'b0;
    data_step = 1'b0;
    unique case (phase_q)
      dfr_pkg::PhHdr2: begin
        bits_v  = din_word_i[dfr_pkg::CntW-1:0];
        phase_d = dfr_pkg::PhData;
        slot_d  = '0;
        emit    = (words_q == '0);
      end
      dfr_pkg::PhData: begin
        data_step = 1'b1;
        words_v   = words_q - dfr_pkg::CntW'(words_q != '0);
        slot_d    = slot_q + SlotW'(1);
        emit      = (slot_d >= SlotFull) || (words_v == '0);
      end
      default: begin
        words_v = din_word_i[dfr_pkg::CntLsb +: dfr_pkg::CntW];
        final_v = din_word_i[dfr_pkg::FinalBit];
        slot_d  = '0;
        if (final_v) begin
          phase_d = dfr_pkg::PhHdr2;
        end else begin
          bits_v  = din_word_i[dfr_pkg::CntW-1:0];
          phase_d = dfr_pkg::PhData;
          emit    = (words_v == '0);
        end
      end
    endcase

    // Block trailer: saturate the bit count and close the segment when words run out
    end_d   = (words_v == '0) && final_v;
    nbits_d = '0;
    if (bits_v >= BlockBits) begin
      nbits_d = dfr_pkg::BitsW'(BlockBits);
    end else begin
      nbits_d = bits_v[dfr_pkg::BitsW-1:0];
    end
    if (emit) begin
      if (bits_v >= BlockBits) begin
        bits_v = bits_v - BlockBits;
      end else begin
        bits_v = '0;
      end
      slot_d = '0;
      if (words_v == '0) begin
        phase_d = dfr_pkg::PhHdr1;
      end
    end
    words_d = words_v;
    bits_d  = bits_v;
    final_d = final_v;
  end

  // Handshakes: hold input only when it would load a busy output row
  assign out_last    = (idx_q == LastIdx);
  assign out_fire    = busy_q && dout_ready_i;
  assign out_free    = !busy_q || (dout_ready_i && out_last);
  assign din_ready_o = out_free || !emit;
  assign in_fire     = din_valid_i && din_ready_o;

  assign in_ctl.load   = 1'b0;
  assign in_ctl.shift  = in_fire && data_step;
  assign out_ctl.load  = in_fire && emit;
  assign out_ctl.shift = out_fire;

  // Output sequencing
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (out_ctl.load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (out_fire) begin
      idx_d = idx_q + dfr_pkg::IdxW'(1);
      if (out_last) begin
        busy_d = 1'b0;
      end
    end
  end

  // Advance segment state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dfr_pkg::PhHdr1;
      final_q <= 1'b0;
      words_q <= '0;
      bits_q  <= '0;
      slot_q  <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      final_q <= final_d;
      words_q <= words_d;
      bits_q  <= bits_d;
      slot_q  <= slot_d;
    end
  end

  // Output row control and block trailer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      nbits_q <= '0;
      end_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (out_ctl.load) begin
        nbits_q <= nbits_d;
        end_q   <= end_q ^ (end_q ^ end_d);
      end
    end
  end

  // Two cell rows: packing row shifts toward index 0, output row drains from index 0
  for (genvar k = 0; k < Wpb; k++) begin : g_cells
    logic [dfr_pkg::WordW-1:0] in_nb;
    logic [dfr_pkg::WordW-1:0] out_nb;

    if (k == Wpb - 1) begin : g_tail
      assign in_nb  = din_word_i;
      assign out_nb = '0;
    end else begin : g_body
      assign in_nb  = store_q[k+1];
      assign out_nb = out_q[k+1];
    end

    dfr_cell u_pack_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (in_ctl),
      .load_i  ('0),
      .shift_i (in_nb),
      .q_o     (store_q[k]),
      .nxt_o   (store_nxt[k])
    );

    dfr_cell u_out_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (out_ctl),
      .load_i  (store_nxt[k]),
      .shift_i (out_nb),
      .q_o     (out_q[k]),
      .nxt_o   (out_nxt[k])
    );
  end

  // Result ports
  assign dout_valid_o  = busy_q;
  assign block_word_o  = out_q[0];
  assign word_index_o  = idx_q;
  assign block_bits_o  = out_last ? nbits_q : '0;
  assign message_end_o = out_last && end_q;
  assign block_done_o  = out_last;

endmodule

`default_nettype wire
